// ----- hdl/albs_pkg.sv -----
// Shared types and codes for the search store block.
// No dependencies; compiled first.
package albs_pkg;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_LINEAR = 2'd2,
    OP_SORTED = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_DONE     = 3'd0,
    ST_FOUND    = 3'd1,
    ST_NOTFOUND = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_FULL     = 3'd4
  } rsp_code_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_L_RD,
    S_L_CMP,
    S_PIV_RD,
    S_PIV,
    S_SRT_RD,
    S_SRT_CMP,
    S_SRT_WB,
    S_B_INIT,
    S_B_RD,
    S_B_CMP,
    S_FIN
  } state_t;

  typedef enum logic [1:0] {
    RD_I,
    RD_J,
    RD_MID
  } rd_sel_t;

  typedef enum logic [1:0] {
    POS_NONE,
    POS_J,
    POS_MID
  } pos_sel_t;

  typedef struct packed {
    logic      load;
    logic      clr_count;
    logic      append;
    logic      set_i0;
    logic      inc_i;
    logic      set_j_i1;
    logic      set_j0;
    logic      inc_j;
    rd_sel_t   rd_sel;
    logic      ld_pivot;
    logic      swap;
    logic      wb_i;
    logic      bin_init;
    logic      mid_cap;
    logic      bin_lo;
    logic      bin_hi;
    logic      set_res;
    rsp_code_t res_code;
    pos_sel_t  res_pos;
    logic      publish;
  } albs_cmd_t;

  typedef struct packed {
    op_t  op;
    logic empty;
    logic full;
    logic one;
    logic j_last;
    logic i_last;
    logic match;
    logic less_key;
    logic less_piv;
    logic lo_lt_hi;
    logic out_free;
  } albs_stat_t;

endpackage

// ----- hdl/albs_req_if.sv -----
// Request channel: operation and value words with valid/ready.
// Standalone; no package dependency.
interface albs_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         operation;
  logic signed [31:0] value;

  modport source (output valid, output operation, output value, input ready);
  modport sink (input valid, input operation, input value, output ready);
endinterface

// ----- hdl/albs_rsp_if.sv -----
// Response channel: status and position words with valid/ready.
// Standalone; no package dependency.
interface albs_rsp_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [7:0] position;

  modport source (output valid, output status, output position, input ready);
  modport sink (input valid, input status, input position, output ready);
endinterface

// ----- hdl/albs_ctrl.sv -----
// Sequencer for clear, append, linear search, exchange sort and binary search.
// Depends on albs_pkg; drives the datapath through albs_cmd_t.
module albs_ctrl import albs_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  albs_stat_t stat,
  output albs_cmd_t  cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        state_next = S_FIN;
        case (stat.op)
          OP_CLEAR: begin
            cmd.clr_count = 1'b1;
            cmd.set_res   = 1'b1;
            cmd.res_code  = ST_DONE;
          end
          OP_APPEND: begin
            cmd.set_res  = 1'b1;
            cmd.append   = !stat.full;
            cmd.res_code = stat.full ? ST_FULL : ST_DONE;
          end
          OP_LINEAR: begin
            if (stat.empty) begin
              cmd.set_res  = 1'b1;
              cmd.res_code = ST_EMPTY;
            end else begin
              cmd.set_j0 = 1'b1;
              state_next = S_L_RD;
            end
          end
          OP_SORTED: begin
            if (stat.empty) begin
              cmd.set_res  = 1'b1;
              cmd.res_code = ST_EMPTY;
            end else if (stat.one) begin
              state_next = S_B_INIT;
            end else begin
              cmd.set_i0 = 1'b1;
              state_next = S_PIV_RD;
            end
          end
          default: state_next = S_IDLE;
        endcase
      end
      S_L_RD: begin
        cmd.rd_sel = RD_J;
        state_next = S_L_CMP;
      end
      S_L_CMP: begin
        if (stat.match) begin
          cmd.set_res  = 1'b1;
          cmd.res_code = ST_FOUND;
          cmd.res_pos  = POS_J;
          state_next   = S_FIN;
        end else if (stat.j_last) begin
          cmd.set_res  = 1'b1;
          cmd.res_code = ST_NOTFOUND;
          state_next   = S_FIN;
        end else begin
          cmd.inc_j  = 1'b1;
          state_next = S_L_RD;
        end
      end
      S_PIV_RD: begin
        cmd.rd_sel = RD_I;
        state_next = S_PIV;
      end
      S_PIV: begin
        cmd.ld_pivot = 1'b1;
        cmd.set_j_i1 = 1'b1;
        state_next   = S_SRT_RD;
      end
      S_SRT_RD: begin
        cmd.rd_sel = RD_J;
        state_next = S_SRT_CMP;
      end
      S_SRT_CMP: begin
        cmd.swap = stat.less_piv;
        if (stat.j_last) begin
          state_next = S_SRT_WB;
        end else begin
          cmd.inc_j  = 1'b1;
          state_next = S_SRT_RD;
        end
      end
      S_SRT_WB: begin
        cmd.wb_i = 1'b1;
        if (stat.i_last) begin
          state_next = S_B_INIT;
        end else begin
          cmd.inc_i  = 1'b1;
          state_next = S_PIV_RD;
        end
      end
      S_B_INIT: begin
        cmd.bin_init = 1'b1;
        state_next   = S_B_RD;
      end
      S_B_RD: begin
        if (stat.lo_lt_hi) begin
          cmd.rd_sel  = RD_MID;
          cmd.mid_cap = 1'b1;
          state_next  = S_B_CMP;
        end else begin
          cmd.set_res  = 1'b1;
          cmd.res_code = ST_NOTFOUND;
          state_next   = S_FIN;
        end
      end
      S_B_CMP: begin
        if (stat.match) begin
          cmd.set_res  = 1'b1;
          cmd.res_code = ST_FOUND;
          cmd.res_pos  = POS_MID;
          state_next   = S_FIN;
        end else begin
          cmd.bin_lo = stat.less_key;
          cmd.bin_hi = !stat.less_key;
          state_next = S_B_RD;
        end
      end
      S_FIN: begin
        if (stat.out_free) begin
          cmd.publish = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ----- hdl/albs_dpath.sv -----
// Element store, count, loop indices, search window and response register.
// Depends on albs_pkg; commanded by albs_ctrl.
module albs_dpath import albs_pkg::*; #(
  parameter int CAPACITY = 128
) (
  input  logic               clk,
  input  logic               rst,
  input  albs_cmd_t          cmd,
  output albs_stat_t         stat,
  input  logic [1:0]         operation,
  input  logic signed [31:0] value,
  input  logic               rsp_ready,
  output logic               rsp_valid,
  output logic [2:0]         rsp_status,
  output logic [7:0]         rsp_position
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  logic signed [31:0] mem [CAPACITY];
  logic signed [31:0] rdata;
  logic signed [31:0] key;
  logic signed [31:0] pivot;
  op_t                op;
  logic [CW-1:0]      count;
  logic [AW-1:0]      i, j, mid;
  logic [CW-1:0]      lo, hi;
  logic [CW-1:0]      mid_w;
  logic [AW-1:0]      ra, wa;
  logic               we;
  logic signed [31:0] wd;
  rsp_code_t          res_code;
  logic [CW-1:0]      res_pos;

  assign mid_w = lo + ((hi - CW'(1) - lo) >> 1);

  always_comb begin
    case (cmd.rd_sel)
      RD_I:    ra = i;
      RD_J:    ra = j;
      RD_MID:  ra = mid_w[AW-1:0];
      default: ra = i;
    endcase
  end

  assign we = cmd.append | cmd.swap | cmd.wb_i;
  assign wa = cmd.append ? count[AW-1:0] : (cmd.swap ? j : i);
  assign wd = cmd.append ? key : pivot;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rdata <= mem[ra];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op  <= op_t'(operation);
      key <= value;
    end
    if (cmd.ld_pivot || cmd.swap) begin
      pivot <= rdata;
    end
    if (cmd.set_i0) begin
      i <= '0;
    end else if (cmd.inc_i) begin
      i <= i + AW'(1);
    end
    if (cmd.set_j0) begin
      j <= '0;
    end else if (cmd.set_j_i1) begin
      j <= i + AW'(1);
    end else if (cmd.inc_j) begin
      j <= j + AW'(1);
    end
    if (cmd.bin_init) begin
      lo <= '0;
      hi <= count;
    end else if (cmd.bin_lo) begin
      lo <= CW'(mid) + CW'(1);
    end else if (cmd.bin_hi) begin
      hi <= CW'(mid);
    end
    if (cmd.mid_cap) begin
      mid <= mid_w[AW-1:0];
    end
    if (cmd.set_res) begin
      res_code <= cmd.res_code;
      case (cmd.res_pos)
        POS_J:   res_pos <= CW'(j) + CW'(1);
        POS_MID: res_pos <= CW'(mid) + CW'(1);
        default: res_pos <= '0;
      endcase
    end
    if (cmd.publish) begin
      rsp_status   <= res_code;
      rsp_position <= 8'(res_pos);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (cmd.clr_count) begin
        count <= '0;
      end else if (cmd.append) begin
        count <= count + CW'(1);
      end
      if (cmd.publish) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    stat          = '0;
    stat.op       = op;
    stat.empty    = (count == '0);
    stat.full     = (count == CW'(CAPACITY));
    stat.one      = (count == CW'(1));
    stat.j_last   = (CW'(j) == count - CW'(1));
    stat.i_last   = (CW'(i) + CW'(2) == count);
    stat.match    = (rdata == key);
    stat.less_key = (rdata < key);
    stat.less_piv = (rdata < pivot);
    stat.lo_lt_hi = (lo < hi);
    stat.out_free = !rsp_valid || rsp_ready;
  end

endmodule

// ----- hdl/array_linear_binary_search.sv -----
// Search store: holds up to CAPACITY signed 32-bit words in a memory with
// one write port and one registered read port, and runs clear, append, linear
// search and sort-then-binary-search, one request at a time. A linear search
// reads and then compares each entry that it visits. A sorted search runs an
// exchange sort of the entries (skipped for a single entry), then a binary
// search that reads and then compares one probe at a time. A new request is
// taken while the previous response waits in the output register.
// Depends on albs_pkg, albs_req_if, albs_rsp_if, albs_ctrl and albs_dpath.
module array_linear_binary_search import albs_pkg::*; #(
  parameter int CAPACITY = 128
) (
  input  logic           clk,
  input  logic           rst,
  albs_req_if.sink       req,
  albs_rsp_if.source     rsp
);

  albs_cmd_t  cmd;
  albs_stat_t stat;

  albs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  albs_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .operation    (req.operation),
    .value        (req.value),
    .rsp_ready    (rsp.ready),
    .rsp_valid    (rsp.valid),
    .rsp_status   (rsp.status),
    .rsp_position (rsp.position)
  );

endmodule

// ----- hdl/albs_check.sv -----
// Port-level checks for the search store, bound to the top level.
// Depends on albs_pkg and array_linear_binary_search.
module albs_check import albs_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       req_valid,
  input logic       req_ready,
  input logic       rsp_valid,
  input logic       rsp_ready,
  input logic [2:0] status,
  input logic [7:0] position
);

  logic [1:0] pend;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= '0;
    end else begin
      pend <= pend + 2'((req_valid && req_ready) ? 1 : 0)
                   - 2'((rsp_valid && rsp_ready) ? 1 : 0);
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(position))
    else $error("response changed while stalled");

  a_code: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> status <= ST_FULL)
    else $error("status code out of range");

  a_pos: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status != ST_FOUND |-> position == 8'd0)
    else $error("position set without a match");

  a_owed: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_ready |-> pend != 2'd0)
    else $error("response without a request");

  a_depth: assert property (@(posedge clk) disable iff (rst)
    pend <= 2'd2)
    else $error("too many requests in flight");

endmodule

bind array_linear_binary_search albs_check u_albs_check (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req.valid),
  .req_ready (req.ready),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .status    (rsp.status),
  .position  (rsp.position)
);

// ----- tb/sv/tb_array_linear_binary_search.sv -----
// Self-checking testbench for array_linear_binary_search: drives request words in random
// bursts, stalls the response side, and compares every response with an in-bench predictor.
// Depends on albs_pkg, albs_req_if, albs_rsp_if and the block's RTL.
module tb_array_linear_binary_search;
  import albs_pkg::*;

  localparam int CAPACITY = 128;
  localparam int ITEM_TARGET = 1200;
  localparam int CYCLE_LIMIT = 2000000;

  typedef struct packed {
    rsp_code_t  status;
    logic [7:0] position;
  } search_rsp_t;

  logic clk = 1'b0;
  logic rst;

  albs_req_if req_ch ();
  albs_rsp_if rsp_ch ();

  array_linear_binary_search #(.CAPACITY(CAPACITY)) u_top (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  logic signed [31:0] shadow_store [CAPACITY];
  int                 shadow_count;
  search_rsp_t        rsp_due_q [$];
  int                 mismatches = 0;
  int                 words_sent;
  int                 burst_left;
  int unsigned        cycle_count = 0;
  logic [7:0]         stall_tick;
  int                 stall_mode;

  function automatic void predict_search(op_t op, logic signed [31:0] val);
    search_rsp_t        r;
    int                 lo;
    int                 hi;
    int                 mid;
    bit                 hit;
    logic signed [31:0] t;
    r.status = ST_DONE;
    r.position = 8'd0;
    case (op)
      OP_CLEAR: shadow_count = 0;
      OP_APPEND: begin
        if (shadow_count >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          shadow_store[shadow_count] = val;
          shadow_count++;
        end
      end
      default: begin
        if (shadow_count == 0) begin
          r.status = ST_EMPTY;
        end else if (op == OP_LINEAR) begin
          r.status = ST_NOTFOUND;
          for (int i = 0; i < shadow_count; i++) begin
            if (shadow_store[i] == val) begin
              r.status = ST_FOUND;
              r.position = 8'(i + 1);
              break;
            end
          end
        end else begin
          for (int i = 0; i < shadow_count; i++) begin
            for (int j = i + 1; j < shadow_count; j++) begin
              if (shadow_store[j] < shadow_store[i]) begin
                t = shadow_store[i];
                shadow_store[i] = shadow_store[j];
                shadow_store[j] = t;
              end
            end
          end
          r.status = ST_NOTFOUND;
          lo = 0;
          hi = shadow_count;
          hit = 1'b0;
          while (lo < hi && !hit) begin
            mid = lo + (hi - 1 - lo) / 2;
            if (shadow_store[mid] == val) begin
              hit = 1'b1;
              r.status = ST_FOUND;
              r.position = 8'(mid + 1);
            end else if (shadow_store[mid] < val) begin
              lo = mid + 1;
            end else begin
              hi = mid;
            end
          end
        end
      end
    endcase
    rsp_due_q.push_back(r);
  endfunction

  function automatic logic signed [31:0] pick_element();
    case ($urandom_range(0, 3))
      0, 1: return $signed($urandom_range(0, 16)) - 8;
      2: return $urandom;
      default: return $urandom_range(0, 1) ? 32'sh7fff_ffff : 32'sh8000_0000;
    endcase
  endfunction

  function automatic logic signed [31:0] pick_key();
    if (shadow_count > 0 && $urandom_range(0, 9) < 6)
      return shadow_store[$urandom_range(0, shadow_count - 1)];
    return pick_element();
  endfunction

  task automatic send_word(input op_t op, input logic signed [31:0] val);
    bit taken;
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        req_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    req_ch.valid <= 1'b1;
    req_ch.operation <= op;
    req_ch.value <= val;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = req_ch.ready;
      @(posedge clk);
    end
    predict_search(op, val);
    words_sent++;
  endtask

  task automatic drain_responses();
    req_ch.valid <= 1'b0;
    burst_left = 0;
    while (rsp_due_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic test_empty_store();
    send_word(OP_LINEAR, 32'sd7);
    send_word(OP_SORTED, 32'sh8000_0000);
    send_word(OP_CLEAR, 32'sh7fff_ffff);
    drain_responses();
  endtask

  task automatic test_extremes_and_duplicates();
    send_word(OP_APPEND, 32'sh7fff_ffff);
    send_word(OP_APPEND, 32'sh8000_0000);
    send_word(OP_APPEND, 32'sd0);
    send_word(OP_APPEND, -32'sd1);
    send_word(OP_APPEND, 32'sd5);
    send_word(OP_APPEND, 32'sd5);
    send_word(OP_APPEND, -32'sd5);
    send_word(OP_LINEAR, 32'sh8000_0000);
    send_word(OP_LINEAR, 32'sd5);
    send_word(OP_LINEAR, 32'sd12345);
    send_word(OP_LINEAR, 32'sh7fff_ffff);
    send_word(OP_SORTED, 32'sd5);
    send_word(OP_SORTED, 32'sh8000_0000);
    send_word(OP_SORTED, 32'sd99);
    send_word(OP_SORTED, 32'sh7fff_ffff);
    send_word(OP_LINEAR, -32'sd1);
    send_word(OP_CLEAR, 32'sd0);
    send_word(OP_LINEAR, 32'sd5);
    drain_responses();
  endtask

  task automatic test_full_store();
    send_word(OP_CLEAR, $urandom);
    for (int i = 0; i < CAPACITY - 1; i++) send_word(OP_APPEND, pick_element());
    send_word(OP_APPEND, 32'sh1234_5679);
    repeat (3) send_word(OP_APPEND, $urandom);
    send_word(OP_LINEAR, 32'sh1234_5679);
    send_word(OP_LINEAR, pick_key());
    send_word(OP_SORTED, pick_key());
    send_word(OP_SORTED, $urandom);
    send_word(OP_LINEAR, pick_key());
    send_word(OP_APPEND, $urandom);
    drain_responses();
  endtask

  task automatic test_random_sequences();
    int n_app;
    int n_find;
    while (words_sent < ITEM_TARGET) begin
      if ($urandom_range(0, 9) == 0) begin
        send_word(op_t'($urandom_range(0, 3)), $urandom);
      end else begin
        if ($urandom_range(0, 7) != 0 || shadow_count >= 40) send_word(OP_CLEAR, $urandom);
        n_app = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
        repeat (n_app) send_word(OP_APPEND, pick_element());
        n_find = $urandom_range(1, 6);
        repeat (n_find) begin
          send_word($urandom_range(0, 1) ? OP_LINEAR : OP_SORTED, pick_key());
        end
      end
    end
    drain_responses();
  endtask

  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      stall_tick <= 8'd0;
      stall_mode <= 0;
    end else begin
      stall_tick <= stall_tick + 8'd1;
      if (stall_tick == 8'd0) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
        0: rsp_ch.ready <= 1'b1;
        1: rsp_ch.ready <= $urandom_range(0, 1);
        2: rsp_ch.ready <= (stall_tick[2:0] != 3'd0);
        default: rsp_ch.ready <= (stall_tick[5:4] != 2'd0);
      endcase
    end
  end

  always @(negedge clk) begin
    search_rsp_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (rsp_due_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected response word: status %0d position %0d",
                   rsp_ch.status, rsp_ch.position);
      end else begin
        want = rsp_due_q.pop_front();
        if (rsp_ch.status !== want.status || rsp_ch.position !== want.position) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: status exp %0d got %0d, position exp %0d got %0d",
                     want.status, rsp_ch.status, want.position, rsp_ch.position);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL array_linear_binary_search");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.operation = 2'd0;
    req_ch.value = 32'sd0;
    shadow_count = 0;
    words_sent = 0;
    burst_left = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_empty_store();
    test_extremes_and_duplicates();
    test_full_store();
    test_random_sequences();
    test_full_store();
    if (mismatches == 0 && rsp_due_q.size() == 0) begin
      $display("PASS array_linear_binary_search");
    end else begin
      $display("FAIL array_linear_binary_search");
    end
    $finish;
  end

endmodule
